FILE: hw/rtl/btme_pkg.sv
// Shared types, constants and helper functions of the button turbo and macro engine.
package btme_pkg;

	localparam int BUTTON_COUNT = 15;
	localparam int SLOT_COUNT   = 8;
	localparam int MAX_STEPS    = 16;
	localparam int STEP_TABLE   = SLOT_COUNT * MAX_STEPS;
	localparam int QUEUE_DEPTH  = 4;

	localparam int BTN_W      = 15;
	localparam int NOW_W      = 32;
	localparam int SLOT_W     = 3;
	localparam int STEP_W     = 4;
	localparam int TRIG_W     = 8;
	localparam int CNT_W      = 5;
	localparam int DUR_W      = 16;
	localparam int DURC_W     = 13;
	localparam int THR_W      = 23;
	localparam int ADDR_W     = SLOT_W + STEP_W;
	localparam int HALF_W     = 6;
	localparam int RATE_W     = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 15;
	localparam int IN_DATA_W  = 104;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 24;

	localparam logic [TRIG_W-1:0] NO_TRIGGER  = 8'hFF;
	localparam int                DUR_MAX_MS  = 5000;
	localparam int                US_PER_MS   = 1000;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRE_MASK = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRE_RATE = 1'b1;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_HEADER = 2'd1,
		REQ_STEP   = 2'd2,
		REQ_UNUSED = 2'd3
	} req_t;

	// One classified item as it waits in the queue.
	typedef struct packed {
		req_t              kind;
		logic [BTN_W-1:0]  raw;
		logic [NOW_W-1:0]  now;
		logic [SLOT_W-1:0] slot;
		logic [STEP_W-1:0] step;
		logic [TRIG_W-1:0] trig;
		logic [CNT_W-1:0]  cnt;
		logic [THR_W-1:0]  thr;
		logic [BTN_W-1:0]  mask;
	} work_t;

	// Head of the queue as the back end sees it.
	typedef struct packed {
		logic  valid;
		work_t item;
	} q_head_t;

	// One entry of the step table: step length in microseconds and forced buttons.
	typedef struct packed {
		logic [THR_W-1:0] thr;
		logic [BTN_W-1:0] mask;
	} step_ent_t;

	// Ticks per turbo half period for a 125 Hz tick: 125 / (2 * rate), at least 1,
	// with the rate clamped to 1..120 (every rate above 31 already gives 1).
	function automatic logic [HALF_W-1:0] turbo_half(input logic [RATE_W-1:0] rate);
		logic [HALF_W-1:0] h;
		begin
			if (rate <= 7'd1)       h = 6'd62;
			else if (rate == 7'd2)  h = 6'd31;
			else if (rate == 7'd3)  h = 6'd20;
			else if (rate == 7'd4)  h = 6'd15;
			else if (rate == 7'd5)  h = 6'd12;
			else if (rate == 7'd6)  h = 6'd10;
			else if (rate == 7'd7)  h = 6'd8;
			else if (rate == 7'd8)  h = 6'd7;
			else if (rate <= 7'd10) h = 6'd6;
			else if (rate <= 7'd12) h = 6'd5;
			else if (rate <= 7'd15) h = 6'd4;
			else if (rate <= 7'd20) h = 6'd3;
			else if (rate <= 7'd31) h = 6'd2;
			else                    h = 6'd1;
			return h;
		end
	endfunction

	// Releases the trigger button, if it names a real button.
	function automatic logic [BTN_W-1:0] release_trigger(input logic [BTN_W-1:0] btn,
			input logic [TRIG_W-1:0] trig);
		logic [BTN_W-1:0] r;
		begin
			r = btn;
			if (trig < TRIG_W'(BUTTON_COUNT)) begin
				r = btn & ~(BTN_W'(1) << trig[STEP_W-1:0]);
			end
			return r;
		end
	endfunction

endpackage

FILE: hw/rtl/button_turbo_macro_engine.sv
// Top level of the gamepad turbo autofire and macro playback engine.
// A tick item's result reaches m_tdata through the queue and the result register.
// Throughput: one item per cycle while nothing stalls; the back end holds the queue after a tick that
// starts or advances playback and after a step write, while the step table's registered
// read ports catch up. A four-entry queue absorbs these bubbles and output stalls.
// Reset (arst_n, asynchronous): turbo, playback and slot headers clear; steps stay unset.
module button_turbo_macro_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input items.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// Low to high: raw_buttons, now_us, slot_index, step_index, trigger_button,
	// slot_steps, step length in ms, step_buttons, zero pad.
	input  logic [btme_pkg::IN_DATA_W-1:0]   s_tdata,
	// req_type.
	input  logic [btme_pkg::IN_USER_W-1:0]   s_tuser,
	// Result items.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// Low to high: out_buttons, macro_busy, playing_slot, zero pad.
	output logic [btme_pkg::OUT_DATA_W-1:0]  m_tdata,
	// Configuration writes: 0 autofire button enables, 1 autofire rate in hertz.
	input  logic                             cfg_we,
	input  logic [btme_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [btme_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	// The front end only decodes: it clamps step durations into microsecond
	// thresholds and saturates step counts, so the back end's tick path is one
	// subtract and compare against the stored threshold.
	logic              q_full;
	logic              q_push;
	logic              q_pop;
	btme_pkg::work_t   q_item;
	btme_pkg::q_head_t q_head;

	btme_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_item)
	);

	btme_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head)
	);

	// The back end owns all state; it takes one queued item per cycle whenever the result
	// register is free or being emptied, the step table reads are current and no configuration
	// write is under way, so a result that waits on the receiver holds back every queued item.
	btme_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.head      (q_head),
		.pop       (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

FILE: hw/rtl/btme_front.sv
// Front end: takes input items, decodes and classifies them, and queues them.
module btme_front (
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [btme_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [btme_pkg::IN_USER_W-1:0]  s_tuser,
	input  logic                            q_full,
	output logic                            q_push,
	output btme_pkg::work_t                 q_item
);

	btme_pkg::req_t                    kind;
	logic [btme_pkg::DUR_W-1:0]        dur;
	logic [btme_pkg::DURC_W-1:0]       dur_c;
	logic [btme_pkg::CNT_W-1:0]        steps;
	logic                              keep;

	assign kind  = btme_pkg::req_t'(s_tuser);
	assign dur   = s_tdata[82:67];
	assign steps = s_tdata[66:62];

	always_comb begin
		if (dur == '0) begin
			dur_c = btme_pkg::DURC_W'(1);
		end else if (dur > btme_pkg::DUR_W'(btme_pkg::DUR_MAX_MS)) begin
			dur_c = btme_pkg::DURC_W'(btme_pkg::DUR_MAX_MS);
		end else begin
			dur_c = dur[btme_pkg::DURC_W-1:0];
		end
	end

	always_comb begin
		unique case (kind)
			btme_pkg::REQ_TICK,
			btme_pkg::REQ_HEADER,
			btme_pkg::REQ_STEP:   keep = 1'b1;
			btme_pkg::REQ_UNUSED: keep = 1'b0;
		endcase
	end

	always_comb begin
		q_item.kind = kind;
		q_item.raw  = s_tdata[14:0];
		q_item.now  = s_tdata[46:15];
		q_item.slot = s_tdata[49:47];
		q_item.step = s_tdata[53:50];
		q_item.trig = s_tdata[61:54];
		// Step counts above the table depth saturate.
		q_item.cnt  = (steps > btme_pkg::CNT_W'(btme_pkg::MAX_STEPS)) ?
			btme_pkg::CNT_W'(btme_pkg::MAX_STEPS) : steps;
		q_item.thr  = btme_pkg::THR_W'(dur_c) * btme_pkg::THR_W'(btme_pkg::US_PER_MS);
		q_item.mask = s_tdata[97:83];
	end

	assign s_tready = !q_full;
	// Items of the unused request type are taken and dropped here.
	assign q_push   = s_tvalid && !q_full && keep;

endmodule

FILE: hw/rtl/btme_fifo.sv
// Short queue of classified items between the front end and the back end.
module btme_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  btme_pkg::work_t   push_item,
	output logic              full,
	input  logic              pop,
	output btme_pkg::q_head_t head
);

	localparam int PTR_W = $clog2(btme_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(btme_pkg::QUEUE_DEPTH + 1);

	btme_pkg::work_t   entry_q [btme_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(btme_pkg::QUEUE_DEPTH - 1)) ? '0 :
					wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(btme_pkg::QUEUE_DEPTH - 1)) ? '0 :
					rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	assign full       = (count_q == CNT_W'(btme_pkg::QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = entry_q[rd_ptr_q];

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue count lost a push");

endmodule

FILE: hw/rtl/btme_back.sv
// Back end: turbo, macro playback, slot headers, step table and the result register.
module btme_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [btme_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [btme_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  btme_pkg::q_head_t                head,
	output logic                             pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [btme_pkg::OUT_DATA_W-1:0]  m_tdata
);

	localparam int BTN_W  = btme_pkg::BTN_W;
	localparam int SLOT_W = btme_pkg::SLOT_W;
	localparam int STEP_W = btme_pkg::STEP_W;
	localparam int CNT_W  = btme_pkg::CNT_W;
	localparam int TRIG_W = btme_pkg::TRIG_W;
	localparam int NOW_W  = btme_pkg::NOW_W;
	localparam int HALF_W = btme_pkg::HALF_W;

	btme_pkg::work_t w;

	// Configuration.
	logic [BTN_W-1:0]            fire_mask_q;
	logic [btme_pkg::RATE_W-1:0] turbo_rate_q;

	// Turbo state.
	logic [HALF_W-1:0] ticks_q [btme_pkg::BUTTON_COUNT];
	logic [HALF_W-1:0] ticks_d [btme_pkg::BUTTON_COUNT];
	logic [BTN_W-1:0]  phase_q;
	logic [BTN_W-1:0]  phase_d;
	logic [HALF_W-1:0] half;

	// Playback state and slot headers.
	logic              playing_q;
	logic [SLOT_W-1:0] play_slot_q;
	logic [CNT_W-1:0]  play_step_q;
	logic [NOW_W-1:0]  start_us_q;
	logic [BTN_W-1:0]  prev_raw_q;
	logic [TRIG_W-1:0] trig_q [btme_pkg::SLOT_COUNT];
	logic [CNT_W-1:0]  cnt_q  [btme_pkg::SLOT_COUNT];
	logic [BTN_W-1:0]  first_mask_q [btme_pkg::SLOT_COUNT];

	// Step table with two registered read ports: current step and next step.
	btme_pkg::step_ent_t          step_mem_q [btme_pkg::STEP_TABLE];
	btme_pkg::step_ent_t          rd_cur_q;
	logic [BTN_W-1:0]             rd_nxt_mask_q;
	logic [btme_pkg::ADDR_W-1:0]  addr_cur;
	logic [btme_pkg::ADDR_W-1:0]  addr_nxt;
	logic                         stale_q;

	// Result register.
	logic              out_valid_q;
	logic [BTN_W-1:0]  out_buttons_q;
	logic              out_busy_q;
	logic [SLOT_W-1:0] out_slot_q;

	// Tick evaluation.
	logic [BTN_W-1:0]  tout;
	logic [BTN_W-1:0]  rise;
	logic              start_hit;
	logic [SLOT_W-1:0] start_slot;
	logic [TRIG_W-1:0] cur_trig;
	logic [CNT_W-1:0]  cur_cnt;
	logic [CNT_W-1:0]  step_inc;
	logic              nx_playing;
	logic [SLOT_W-1:0] nx_slot;
	logic [CNT_W-1:0]  nx_step;
	logic [NOW_W-1:0]  nx_start;
	logic [BTN_W-1:0]  result;
	logic              moved;
	logic              is_tick;

	assign w       = head.item;
	assign is_tick = (w.kind == btme_pkg::REQ_TICK);
	assign half    = btme_pkg::turbo_half(turbo_rate_q);

	// The table read ports follow the playback position; after the position or
	// the table changes, the queue waits until the registered read data is current again.
	// A configuration write holds the queue for its cycle.
	assign pop = head.valid && !stale_q && !cfg_we && (!out_valid_q || m_tready);

	always_comb begin
		logic [HALF_W-1:0] inc;
		tout = w.raw;
		for (int i = 0; i < btme_pkg::BUTTON_COUNT; i++) begin
			inc = ticks_q[i] + HALF_W'(1);
			if (!fire_mask_q[i] || !w.raw[i]) begin
				ticks_d[i] = '0;
				phase_d[i] = 1'b0;
			end else begin
				if (inc >= half) begin
					ticks_d[i] = '0;
					phase_d[i] = !phase_q[i];
				end else begin
					ticks_d[i] = inc;
					phase_d[i] = phase_q[i];
				end
				tout[i] = !phase_d[i];
			end
		end
	end

	// Lowest-numbered enabled slot whose trigger rises wins.
	always_comb begin
		rise       = w.raw & ~prev_raw_q;
		start_hit  = 1'b0;
		start_slot = '0;
		for (int s = btme_pkg::SLOT_COUNT - 1; s >= 0; s--) begin
			if (trig_q[s] < TRIG_W'(btme_pkg::BUTTON_COUNT) && cnt_q[s] != '0 &&
					rise[trig_q[s][STEP_W-1:0]]) begin
				start_hit  = 1'b1;
				start_slot = SLOT_W'(s);
			end
		end
	end

	assign cur_trig = trig_q[play_slot_q];
	assign cur_cnt  = cnt_q[play_slot_q];
	assign step_inc = play_step_q + CNT_W'(1);

	always_comb begin
		nx_playing = playing_q;
		nx_slot    = play_slot_q;
		nx_step    = play_step_q;
		nx_start   = start_us_q;
		result     = tout;
		moved      = 1'b0;
		if (!playing_q) begin
			if (start_hit) begin
				nx_playing = 1'b1;
				nx_slot    = start_slot;
				nx_step    = '0;
				nx_start   = w.now;
				moved      = 1'b1;
				result     = btme_pkg::release_trigger(tout | first_mask_q[start_slot],
					trig_q[start_slot]);
			end
		end else if (cur_trig == btme_pkg::NO_TRIGGER || cur_cnt == '0 ||
				play_step_q >= cur_cnt) begin
			nx_playing = 1'b0;
		end else if (w.now - start_us_q >= NOW_W'(rd_cur_q.thr)) begin
			nx_step  = step_inc;
			nx_start = w.now;
			moved    = 1'b1;
			if (step_inc >= cur_cnt) begin
				nx_playing = 1'b0;
			end else begin
				result = btme_pkg::release_trigger(tout | rd_nxt_mask_q, cur_trig);
			end
		end else begin
			result = btme_pkg::release_trigger(tout | rd_cur_q.mask, cur_trig);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_mask_q  <= '0;
			turbo_rate_q <= btme_pkg::RATE_W'(1);
			for (int i = 0; i < btme_pkg::BUTTON_COUNT; i++) begin
				ticks_q[i] <= '0;
			end
			phase_q     <= '0;
			playing_q   <= 1'b0;
			play_slot_q <= '0;
			play_step_q <= '0;
			start_us_q  <= '0;
			prev_raw_q  <= '0;
			for (int s = 0; s < btme_pkg::SLOT_COUNT; s++) begin
				trig_q[s] <= '0;
				cnt_q[s]  <= '0;
			end
			stale_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			stale_q <= pop && ((is_tick && moved) || w.kind == btme_pkg::REQ_STEP);
			if (pop && is_tick) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == btme_pkg::CFG_FIRE_MASK) begin
					fire_mask_q <= cfg_wdata[BTN_W-1:0];
				end else if (cfg_index == btme_pkg::CFG_FIRE_RATE) begin
					turbo_rate_q <= cfg_wdata[btme_pkg::RATE_W-1:0];
				end
				for (int i = 0; i < btme_pkg::BUTTON_COUNT; i++) begin
					ticks_q[i] <= '0;
				end
				phase_q <= '0;
			end else if (pop) begin
				unique case (w.kind)
					btme_pkg::REQ_TICK: begin
						ticks_q     <= ticks_d;
						phase_q     <= phase_d;
						playing_q   <= nx_playing;
						play_slot_q <= nx_slot;
						play_step_q <= nx_step;
						start_us_q  <= nx_start;
						prev_raw_q  <= w.raw;
					end
					btme_pkg::REQ_HEADER: begin
						trig_q[w.slot] <= w.trig;
						cnt_q[w.slot]  <= w.cnt;
					end
					btme_pkg::REQ_STEP,
					btme_pkg::REQ_UNUSED: begin
					end
				endcase
			end
		end
	end

	assign addr_cur = {play_slot_q, play_step_q[STEP_W-1:0]};
	assign addr_nxt = {play_slot_q, play_step_q[STEP_W-1:0] + STEP_W'(1)};

	always_ff @(posedge clk) begin
		if (pop && w.kind == btme_pkg::REQ_STEP) begin
			step_mem_q[{w.slot, w.step}] <= '{thr: w.thr, mask: w.mask};
			if (w.step == '0) begin
				first_mask_q[w.slot] <= w.mask;
			end
		end
		rd_cur_q      <= step_mem_q[addr_cur];
		rd_nxt_mask_q <= step_mem_q[addr_nxt].mask;
		if (pop && is_tick) begin
			out_buttons_q <= result;
			out_busy_q    <= nx_playing;
			out_slot_q    <= nx_playing ? nx_slot : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_slot_q, out_busy_q, out_buttons_q};

	a_stale_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stale_q |-> !pop)
		else $error("item processed against a stale step table read");

	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && is_tick) |=> out_valid_q)
		else $error("tick processed without a result");

endmodule
